@@ rtl/ring_cross_dilation_core_macros.svh @@
// Assertion helpers for the ring cross dilation core.
`ifndef RING_CROSS_DILATION_CORE_MACROS_SVH
`define RING_CROSS_DILATION_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RCD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define RCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rcd_pkg.sv @@
package rcd_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int DIM_W   = 11;
   localparam int OFS_W   = 10;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [CH_W-1:0]  WHITE     = 8'hFF;
   localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;
   localparam logic [OFS_W-1:0] OFS_RESET = 10'd1;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_COL_OFFSET   = 2'd2,
      REG_ROW_OFFSET   = 2'd3
   } reg_index_type;

   typedef enum logic {
      ACT_PIXEL = 1'b0,
      ACT_DRAIN = 1'b1
   } action_type;

   typedef struct packed {
      logic valid;
      logic emit;
      logic ring;
      logic left_ok;
      logic right_ok;
      logic up_ok;
      logic down;
      logic last;
      logic wr;
   } stage_type;

endpackage

@@ rtl/ring_cross_dilation_core.sv @@
// Result path: a transaction is registered in stage s1 with its memory reads, then its result in the output reg.
// Throughput: 1 transaction per cycle unless a stalled output holds stage s1; the centre-row and
// upper-flag memories each take one read and one write per cycle, and the next centre pixel is read one column ahead.
// Reset: synchronous, active high; clears counters, pipeline valids and registers to defaults.
// Memory contents are not cleared; each entry is written before it is read within a frame.
`include "ring_cross_dilation_core_macros.svh"

module ring_cross_dilation_core
   import rcd_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [PIX_W-1:0]  req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic              req_tuser,   // action
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [PIX_W-1:0]  rsp_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int XW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int MW  = (XW > YW) ? XW : YW;
   localparam int KW  = ((MW > DIM_W) ? MW : DIM_W) + 2;

   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [OFS_W-1:0] col_ofs_ff, col_ofs_in, row_ofs_ff, row_ofs_in;
   logic [XW-1:0]    col_ff, col_in;
   logic [YW-1:0]    row_ff, row_in;
   logic             draining_ff, draining_in;
   logic             left_ff, left_in;
   stage_type        s1_ff, s1_in;
   logic [XW-1:0]    s1_addr_ff, s1_addr_in;
   logic [PIX_W-1:0] s1_pix_ff, s1_pix_in;
   logic [PIX_W-1:0] cur_pix_ff, cur_pix_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [PIX_W-1:0] centre_mem [MAX_WIDTH];
   logic             upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] cen_rdata_ff;
   logic             up_rdata_ff;

   logic             csr_wr;
   reg_index_type    csr_idx;
   logic             restart;
   logic [KW-1:0]    eff_w, eff_h, x_ext, r_emit, ci, rj;
   logic             accept, is_drain, enter, last_col, last_row;
   logic             col_hit, row_hit, r_ok, x_ok;
   logic [XW-1:0]    rd_addr;
   logic             out_free, s1_adv;
   logic             cf, lf, rf, uf, hot;
   logic [CH_W-1:0]  hot_val;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign restart    = csr_wr & ((csr_idx == REG_FRAME_WIDTH) | (csr_idx == REG_FRAME_HEIGHT));

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      col_ofs_in = col_ofs_ff;
      row_ofs_in = row_ofs_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_FRAME_WIDTH:  width_in   = csr_pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: height_in  = csr_pwdata[DIM_W-1:0];
            REG_COL_OFFSET:   col_ofs_in = csr_pwdata[OFS_W-1:0];
            REG_ROW_OFFSET:   row_ofs_in = csr_pwdata[OFS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         REG_COL_OFFSET:   csr_prdata = CSR_DW'(col_ofs_ff);
         REG_ROW_OFFSET:   csr_prdata = CSR_DW'(row_ofs_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // effective geometry
   always_comb begin
      if (KW'(width_ff) < KW'(3))
         eff_w = KW'(3);
      else if (KW'(width_ff) > KW'(MAX_WIDTH))
         eff_w = KW'(MAX_WIDTH);
      else
         eff_w = KW'(width_ff);
      if (KW'(height_ff) < KW'(3))
         eff_h = KW'(3);
      else if (KW'(height_ff) > KW'(MAX_HEIGHT))
         eff_h = KW'(MAX_HEIGHT);
      else
         eff_h = KW'(height_ff);
   end

   // handshake
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign s1_adv     = s1_ff.valid & (~s1_ff.emit | out_free);
   assign req_tready = ~s1_ff.valid | s1_adv;
   assign accept     = req_tvalid & req_tready;
   assign is_drain   = (action_type'(req_tuser) == ACT_DRAIN);
   assign enter      = accept & (is_drain == draining_ff);

   // front stage: position, ring decode, memory read issue
   assign x_ext    = KW'(col_ff);
   assign ci       = KW'(col_ofs_ff);
   assign rj       = KW'(row_ofs_ff);
   assign last_col = (x_ext + KW'(1) >= eff_w);
   assign last_row = (KW'(row_ff) + KW'(1) >= eff_h);
   assign r_emit   = is_drain ? (eff_h - KW'(1)) : (KW'(row_ff) - KW'(1));
   assign r_ok     = (r_emit >= KW'(1)) & (r_emit + KW'(2) <= eff_h);
   assign x_ok     = (x_ext >= KW'(1)) & (x_ext + KW'(2) <= eff_w);
   assign col_hit  = (x_ext == ci) | (x_ext + ci + KW'(1) == eff_w);
   assign row_hit  = (r_emit == rj) | (r_emit + rj + KW'(1) == eff_h);
   assign rd_addr  = last_col ? '0 : (col_ff + XW'(1));

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      draining_in = draining_ff;
      if (restart) begin
         col_in      = '0;
         row_in      = '0;
         draining_in = 1'b0;
      end else if (enter) begin
         col_in = last_col ? '0 : (col_ff + XW'(1));
         if (is_drain) begin
            if (last_col)
               draining_in = 1'b0;
         end else if (last_col) begin
            if (last_row) begin
               row_in      = '0;
               draining_in = 1'b1;
            end else begin
               row_in = row_ff + YW'(1);
            end
         end
      end
   end

   always_comb begin
      s1_in      = s1_ff;
      s1_addr_in = s1_addr_ff;
      s1_pix_in  = s1_pix_ff;
      if (s1_adv)
         s1_in.valid = 1'b0;
      if (enter) begin
         s1_in.valid    = 1'b1;
         s1_in.emit     = is_drain | (row_ff != '0);
         s1_in.ring     = (r_ok & col_hit) | (x_ok & row_hit);
         s1_in.left_ok  = (col_ff != '0);
         s1_in.right_ok = ~last_col;
         s1_in.up_ok    = (r_emit != '0);
         s1_in.down     = ~is_drain & (req_tdata[CH_W-1:0] != '0);
         s1_in.last     = is_drain & last_col;
         s1_in.wr       = ~is_drain;
         s1_addr_in     = col_ff;
         s1_pix_in      = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (enter) begin
         cen_rdata_ff <= centre_mem[rd_addr];
         up_rdata_ff  <= upper_mem[col_ff];
      end
      if (s1_adv & s1_ff.wr)
         centre_mem[s1_addr_ff] <= s1_pix_ff;
      if (s1_adv & s1_ff.emit)
         upper_mem[s1_addr_ff] <= cf;
   end

   // back stage: cross dilation of the buffered row
   assign cf      = (cur_pix_ff[CH_W-1:0] != '0);
   assign lf      = s1_ff.left_ok & left_ff;
   assign rf      = s1_ff.right_ok & (cen_rdata_ff[CH_W-1:0] != '0);
   assign uf      = s1_ff.up_ok & up_rdata_ff;
   assign hot     = cf | lf | rf | uf | s1_ff.down;
   assign hot_val = hot ? WHITE : '0;

   always_comb begin
      cur_pix_in   = s1_adv ? cen_rdata_ff : cur_pix_ff;
      left_in      = (s1_adv & s1_ff.emit) ? cf : left_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_adv & s1_ff.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = s1_ff.ring ? {hot_val, hot_val, hot_val} : cur_pix_ff;
         rsp_last_in  = s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_RESET;
         height_ff    <= DIM_RESET;
         col_ofs_ff   <= OFS_RESET;
         row_ofs_ff   <= OFS_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         draining_ff  <= 1'b0;
         left_ff      <= 1'b0;
         s1_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ofs_ff   <= col_ofs_in;
         row_ofs_ff   <= row_ofs_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         draining_ff  <= draining_in;
         left_ff      <= left_in;
         s1_ff        <= s1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= s1_addr_in;
      s1_pix_ff   <= s1_pix_in;
      cur_pix_ff  <= cur_pix_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `RCD_ASSERT_NEXT(a_s1_hold, s1_ff.valid && s1_ff.emit && rsp_valid_ff && !rsp_tready, s1_ff.valid, "stalled stage lost its transaction")
   `RCD_ASSERT_IMP(a_no_overrun, req_tvalid && req_tready, !s1_ff.valid || s1_adv, "transaction accepted into a blocked stage")
   `RCD_ASSERT_IMP(a_drain_row, draining_ff, row_ff == '0, "row counter not cleared while draining")

endmodule

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top
   import rcd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W         = MAX_WIDTH_DEF;
   localparam int MAX_H         = MAX_HEIGHT_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 1050;

   localparam logic [PIX_W-1:0] CORNER_IMAGE [9] = '{
      24'hFFFFFF, 24'h000000, 24'h008001,
      24'h000000, 24'h80FF7F, 24'h000000,
      24'h00FF00, 24'h0100FF, 24'h000000
   };

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_end;
   } result_pixel_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [PIX_W-1:0]  req_tdata   = '0;   // red[7:0], green[15:8], blue[23:16]
   logic              req_tuser   = 1'b0; // action
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [PIX_W-1:0]  rsp_tdata;          // out_red[7:0], out_green[15:8], out_blue[23:16]
   logic              rsp_tlast;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // register shadows and dilation state
   logic [DIM_W-1:0] frame_width_reg  = DIM_RESET;
   logic [DIM_W-1:0] frame_height_reg = DIM_RESET;
   logic [OFS_W-1:0] col_offset_reg   = OFS_RESET;
   logic [OFS_W-1:0] row_offset_reg   = OFS_RESET;
   int               next_column      = 0;
   int               next_row         = 0;
   bit [PIX_W-1:0]   buffered_row [MAX_W];
   bit               upper_red_flags [MAX_W];
   bit               left_red         = 1'b0;
   bit               flushing         = 1'b0;

   result_pixel_type expected_pixels [$];

   bit sender_gaps_on  = 1'b0;
   bit sink_stalls_on  = 1'b0;
   int sink_stall_left = 0;

   int mismatch_count  = 0;
   int results_checked = 0;
   int useful_items    = 0;
   int frames_done     = 0;
   int frames_cut      = 0;
   int register_writes = 0;

   ring_cross_dilation_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   initial begin
      #(100_000_000);
      $display("run timed out");
      $display("** ring_cross_dilation_core: FAILED **");
      $finish;
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   function automatic int effective_width();
      if (frame_width_reg < 3) return 3;
      if (frame_width_reg > MAX_W) return MAX_W;
      return int'(frame_width_reg);
   endfunction

   function automatic int effective_height();
      if (frame_height_reg < 3) return 3;
      if (frame_height_reg > MAX_H) return MAX_H;
      return int'(frame_height_reg);
   endfunction

   function automatic void restart_geometry();
      next_column = 0;
      next_row    = 0;
      left_red    = 1'b0;
      flushing    = 1'b0;
   endfunction

   function automatic bit on_ring(input int x, input int r, input int w, input int h);
      int ci;
      int rj;
      bit col_hit;
      bit row_hit;
      ci = int'(col_offset_reg);
      rj = int'(row_offset_reg);
      col_hit = (r >= 1) && (r <= h - 2) && ((x == ci) || (x == w - 1 - ci));
      row_hit = (x >= 1) && (x <= w - 2) && ((r == rj) || (r == h - 1 - rj));
      return col_hit || row_hit;
   endfunction

   // Result for column x of buffered row r; down is the red flag of the pixel below.
   function automatic result_pixel_type dilate_column(input int x, input int r, input bit down,
                                                      input int w, input int h);
      bit [PIX_W-1:0] c;
      bit cf;
      bit lf;
      bit rf;
      bit uf;
      result_pixel_type res;
      c  = buffered_row[x];
      cf = c[23:16] != 0;
      lf = (x > 0) ? left_red : 1'b0;
      rf = (x + 1 < w) ? (buffered_row[x + 1][23:16] != 0) : 1'b0;
      uf = (r > 0) ? upper_red_flags[x] : 1'b0;
      if (on_ring(x, r, w, h)) begin
         res.red   = (cf || lf || rf || uf || down) ? WHITE : '0;
         res.green = res.red;
         res.blue  = res.red;
      end else begin
         res.red   = c[23:16];
         res.green = c[15:8];
         res.blue  = c[7:0];
      end
      res.frame_end      = 1'b0;
      upper_red_flags[x] = cf;
      left_red           = cf;
      return res;
   endfunction

   function automatic void predict_transaction(input action_type act, input logic [7:0] red,
                                               input logic [7:0] green, input logic [7:0] blue);
      int w;
      int h;
      int x;
      int r;
      result_pixel_type res;
      w = effective_width();
      h = effective_height();
      x = next_column;
      if (x >= w) x = 0;
      if (act == ACT_DRAIN) begin
         if (!flushing) return;
         useful_items++;
         res = dilate_column(x, h - 1, 1'b0, w, h);
         res.frame_end = (x + 1 >= w);
         expected_pixels.push_back(res);
         if (x + 1 >= w) begin
            restart_geometry();
            frames_done++;
         end else begin
            next_column = x + 1;
         end
         return;
      end
      if (flushing) return;
      useful_items++;
      r = next_row;
      if (r > 0) begin
         res = dilate_column(x, r - 1, red != 0, w, h);
         expected_pixels.push_back(res);
      end
      buffered_row[x] = {red, green, blue};
      if (x + 1 >= w) begin
         next_column = 0;
         left_red    = 1'b0;
         if (r + 1 >= h) begin
            next_row = 0;
            flushing = 1'b1;
         end else begin
            next_row = r + 1;
         end
      end else begin
         next_column = x + 1;
      end
   endfunction

   function automatic logic [CSR_DW-1:0] register_value(input reg_index_type idx);
      case (idx)
         REG_FRAME_WIDTH:  return CSR_DW'(frame_width_reg);
         REG_FRAME_HEIGHT: return CSR_DW'(frame_height_reg);
         REG_COL_OFFSET:   return CSR_DW'(col_offset_reg);
         default:          return CSR_DW'(row_offset_reg);
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      logic [7:0] red;
      if ($urandom_range(0, 99) < 55) red = '0;
      else if ($urandom_range(0, 9) == 0) red = 8'hFF;
      else red = 8'($urandom_range(1, 255));
      return {red, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
   endfunction

   always @(posedge clock) begin : sink
      result_pixel_type got;
      result_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast};
         if (expected_pixels.size() == 0) begin
            $error("result with no pending transaction: tdata %h tlast %b",
                   rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            results_checked++;
            if (got.red !== want.red) begin
               $error("out_red: expected %0d, got %0d", want.red, got.red);
               mismatch_count++;
            end
            if (got.green !== want.green) begin
               $error("out_green: expected %0d, got %0d", want.green, got.green);
               mismatch_count++;
            end
            if (got.blue !== want.blue) begin
               $error("out_blue: expected %0d, got %0d", want.blue, got.blue);
               mismatch_count++;
            end
            if (got.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
               mismatch_count++;
            end
         end
      end
      if (sink_stall_left > 0) begin
         rsp_tready <= 1'b0;
         sink_stall_left--;
      end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
         sink_stall_left = pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(input action_type act, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
      int gap;
      if (sender_gaps_on && $urandom_range(0, 99) < 25) begin
         gap = pick_gap();
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {blue, green, red};
      do @(posedge clock); while (!req_tready);
      predict_transaction(act, red, green, blue);
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] rgb);
      send_item(ACT_PIXEL, rgb[23:16], rgb[15:8], rgb[7:0]);
   endtask

   task automatic send_drain();
      send_item(ACT_DRAIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
   endtask

   // Hold the stream until every pending result is out and the pipeline is empty.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit write, input reg_index_type idx,
                             input logic [CSR_DW-1:0] wdata, output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(input reg_index_type idx);
      logic [CSR_DW-1:0] rdata;
      csr_access(1'b0, idx, '0, rdata);
      if (rdata !== register_value(idx)) begin
         $error("%s readback: expected %0d, got %0d", idx.name(), register_value(idx), rdata);
         mismatch_count++;
      end
   endtask

   task automatic write_register(input reg_index_type idx, input int value);
      logic [CSR_DW-1:0] wdata;
      logic [CSR_DW-1:0] rdata;
      wdata = CSR_DW'(value);
      if ($urandom_range(0, 1)) begin
         if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) wdata |= $urandom() << DIM_W;
         else wdata |= $urandom() << OFS_W;
      end
      csr_access(1'b1, idx, wdata, rdata);
      case (idx)
         REG_FRAME_WIDTH: begin
            frame_width_reg = wdata[DIM_W-1:0];
            restart_geometry();
         end
         REG_FRAME_HEIGHT: begin
            frame_height_reg = wdata[DIM_W-1:0];
            restart_geometry();
         end
         REG_COL_OFFSET: col_offset_reg = wdata[OFS_W-1:0];
         default:        row_offset_reg = wdata[OFS_W-1:0];
      endcase
      register_writes++;
      check_register(idx);
   endtask

   task automatic pick_idle_mode();
      int mode;
      mode = $urandom_range(0, 3);
      sender_gaps_on = mode[0];
      sink_stalls_on = mode[1];
   endtask

   task automatic run_frame(input bit with_noise);
      int w;
      int h;
      int cut;
      w = effective_width();
      h = effective_height();
      cut = (with_noise && $urandom_range(0, 9) == 0) ? $urandom_range(0, w * h - 1) : -1;
      if (with_noise && $urandom_range(0, 9) == 0) send_drain();
      for (int i = 0; i < w * h; i++) begin
         if (i == cut) begin
            // drop the rest of the frame: a geometry write restarts it
            wait_idle();
            write_register(REG_FRAME_WIDTH, int'(frame_width_reg));
            frames_cut++;
            return;
         end
         if (with_noise && $urandom_range(0, 59) == 0) begin
            wait_idle();
            if ($urandom_range(0, 1)) write_register(REG_COL_OFFSET, $urandom_range(0, w));
            else write_register(REG_ROW_OFFSET, $urandom_range(0, h));
         end
         if (with_noise && $urandom_range(0, 49) == 0) send_drain();
         send_pixel(random_pixel());
      end
      for (int i = 0; i < w; i++) begin
         if (with_noise && $urandom_range(0, 29) == 0) send_pixel(random_pixel());
         send_drain();
      end
   endtask

   task automatic test_register_defaults();
      check_register(REG_FRAME_WIDTH);
      check_register(REG_FRAME_HEIGHT);
      check_register(REG_COL_OFFSET);
      check_register(REG_ROW_OFFSET);
   endtask

   task automatic test_directed_corners();
      wait_idle();
      sender_gaps_on = 1'b1;
      sink_stalls_on = 1'b1;
      write_register(REG_FRAME_WIDTH, 0);
      write_register(REG_FRAME_HEIGHT, 1);
      write_register(REG_COL_OFFSET, 0);
      write_register(REG_ROW_OFFSET, 0);
      send_item(ACT_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      for (int i = 0; i < 9; i++) send_pixel(CORNER_IMAGE[i]);
      send_item(ACT_PIXEL, 8'hFF, 8'h00, 8'hFF);
      for (int i = 0; i < 3; i++) send_drain();
      send_drain();
      wait_idle();
      write_register(REG_FRAME_WIDTH, 4);
      write_register(REG_FRAME_HEIGHT, 2);
      write_register(REG_COL_OFFSET, 1);
      write_register(REG_ROW_OFFSET, 1023);
      for (int i = 0; i < 6; i++) send_pixel(random_pixel());
      wait_idle();
      write_register(REG_FRAME_WIDTH, 4);
      frames_cut++;
   endtask

   task automatic test_random_frames();
      int start;
      int wv;
      int hv;
      int ew;
      int eh;
      start = useful_items;
      while (useful_items - start < RANDOM_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0:       wv = $urandom_range(0, 2);
            1:       wv = $urandom_range(11, 40);
            default: wv = $urandom_range(3, 10);
         endcase
         case ($urandom_range(0, 9))
            0:       hv = $urandom_range(0, 2);
            1:       hv = $urandom_range(9, 16);
            default: hv = $urandom_range(3, 8);
         endcase
         ew = (wv < 3) ? 3 : wv;
         eh = (hv < 3) ? 3 : hv;
         write_register(REG_FRAME_WIDTH, wv);
         write_register(REG_FRAME_HEIGHT, hv);
         case ($urandom_range(0, 4))
            0:       write_register(REG_COL_OFFSET, 0);
            1:       write_register(REG_COL_OFFSET, $urandom_range(0, 1023));
            default: write_register(REG_COL_OFFSET, $urandom_range(1, ew / 2));
         endcase
         case ($urandom_range(0, 4))
            0:       write_register(REG_ROW_OFFSET, 0);
            1:       write_register(REG_ROW_OFFSET, $urandom_range(0, 1023));
            default: write_register(REG_ROW_OFFSET, $urandom_range(1, eh / 2));
         endcase
         repeat ($urandom_range(1, 3)) begin
            pick_idle_mode();
            run_frame(1'b1);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults();
      test_directed_corners();
      test_random_frames();
      wait_idle();
      $display("Covered %0d frames (%0d cut short), %0d result pixels, %0d register writes.",
               frames_done, frames_cut, results_checked, register_writes);
      $display("Included saturated sizes, off-frame ring offsets, stray items and idle pauses.");
      if (mismatch_count == 0) begin
         $display("** ring_cross_dilation_core: PASSED **");
      end else begin
         $display("** ring_cross_dilation_core: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/rcd_pkg.sv
rtl/ring_cross_dilation_core.sv
sim/tb_top.sv
